### rtl/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg: shared definitions for the RPN stack evaluator
// Token codes, status codes, stack sizing and the ALU request/response types.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int WORD_W      = 32;
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int STEP_W      = $clog2(WORD_W);

    // token codes
    localparam logic [2:0] FN_PUSH   = 3'd0;
    localparam logic [2:0] FN_ADD    = 3'd1;
    localparam logic [2:0] FN_SUB    = 3'd2;
    localparam logic [2:0] FN_MUL    = 3'd3;
    localparam logic [2:0] FN_DIV    = 3'd4;
    localparam logic [2:0] FN_FINISH = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FEW     = 3'd1;
    localparam logic [2:0] ST_DIVZERO = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_DEPTH   = 3'd4;
    localparam logic [2:0] ST_BADOP   = 3'd5;

    typedef struct packed {
        logic              start;
        logic [2:0]        op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } alu_rsp_t;

endpackage

### rtl/rpn_stack_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_evaluator: integer reverse Polish expression evaluator
// Takes one token per request, keeps an operand stack and answers every
// token with one result (status, and the value on a finish token).
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   --------------------   ------------------------------
//  input     in_valid / in_ready    func, operand_value
//  output    out_valid / out_ready  answer, status, is_final
//
//  Steps: push, finish, error and bad-operator tokens answer from idle.
//  Add, sub and mul run stack read, ALU launch, then ALU result with
//  write-back; div runs stack read, ALU launch, the shared ALU's
//  one-bit-a-cycle restoring divider over 32 quotient bits, a sign-fix
//  step and write-back.
//  Reset clears the depth, the sticky error and the sequencer; stack
//  contents are not cleared, since only written entries are ever read.
//  A new request is taken only while the sequencer is idle and the result
//  register is empty or being drained in the same cycle.
//
module rpn_stack_evaluator (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2:0]                func,
    input  logic signed [31:0]        operand_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [31:0]        answer,
    output logic [2:0]                status,
    output logic                      is_final
);
    import rpn_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;   // wait for a request
    localparam logic [1:0] S_EXEC = 2'd1;   // second operand is out of RAM
    localparam logic [1:0] S_WAIT = 2'd2;   // ALU busy

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  depth_reg, depth_next;
    logic [2:0]        err_reg, err_next;
    logic [WORD_W-1:0] top_reg, top_next;     // top of stack lives here
    logic [2:0]        op_reg, op_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] answer_reg, answer_next;
    logic [2:0]        status_reg, status_next;
    logic              final_reg, final_next;

    logic              accept;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [WORD_W-1:0] rd_data;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    // the RAM holds every entry below the top; entry k sits at address k
    assign wr_addr = ADDR_W'(depth_reg - CNT_W'(1));
    assign rd_addr = ADDR_W'(depth_reg - CNT_W'(2));

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    rpn_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_en   (ram_re),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rpn_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        err_next       = err_reg;
        top_next       = top_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && !out_ready;
        answer_next    = answer_reg;
        status_next    = status_reg;
        final_next     = final_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        alu_req.start  = 1'b0;
        alu_req.op     = op_reg;
        alu_req.a      = rd_data;
        alu_req.b      = top_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // most tokens answer at once; operators clear this below
                    out_valid_next = 1'b1;
                    answer_next    = '0;
                    final_next     = 1'b0;
                    if (func == FN_FINISH)
                    begin
                        final_next = 1'b1;
                        if (err_reg != ST_OK)
                        begin
                            status_next = err_reg;
                        end
                        else if (depth_reg != CNT_W'(1))
                        begin
                            status_next = ST_DEPTH;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            answer_next = top_reg;
                        end
                        depth_next = '0;
                        err_next   = ST_OK;
                    end
                    else if (err_reg != ST_OK)
                    begin
                        // error pending: hold the stack, repeat the error
                        status_next = err_reg;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        case (func) inside
                            FN_PUSH:
                            begin
                                if (depth_reg == CNT_W'(STACK_DEPTH))
                                begin
                                    err_next    = ST_FULL;
                                    status_next = ST_FULL;
                                end
                                else
                                begin
                                    // spill the old top into the RAM
                                    ram_we     = (depth_reg != '0);
                                    top_next   = operand_value;
                                    depth_next = depth_reg + CNT_W'(1);
                                end
                            end
                            FN_ADD, FN_SUB, FN_MUL, FN_DIV:
                            begin
                                if (depth_reg < CNT_W'(2))
                                begin
                                    err_next    = ST_FEW;
                                    status_next = ST_FEW;
                                end
                                else if (func == FN_DIV && top_reg == '0)
                                begin
                                    err_next    = ST_DIVZERO;
                                    status_next = ST_DIVZERO;
                                end
                                else
                                begin
                                    // fetch second-from-top, answer later
                                    out_valid_next = 1'b0;
                                    ram_re         = 1'b1;
                                    op_next        = func;
                                    state_next     = S_EXEC;
                                end
                            end
                            default:
                            begin
                                err_next    = ST_BADOP;
                                status_next = ST_BADOP;
                            end
                        endcase
                    end
                end
            end
            S_EXEC:
            begin
                alu_req.start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    // drop the popped operand, the result becomes the top
                    top_next       = alu_rsp.result;
                    depth_next     = depth_reg - CNT_W'(1);
                    out_valid_next = 1'b1;
                    answer_next    = '0;
                    status_next    = ST_OK;
                    final_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        op_reg     <= op_next;
        answer_reg <= answer_next;
        status_reg <= status_next;
        final_reg  <= final_next;
    end

    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;
    assign status    = status_reg;
    assign is_final  = final_reg;

endmodule

### rtl/rpn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/rpn_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_alu: shared arithmetic unit
// Add, sub and mul finish in the cycle after start; div runs a restoring
// divider over magnitudes, one quotient bit a cycle, then fixes the sign.
// ----------------------------------------------------------------------------
module rpn_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::alu_req_t req,
    output rpn_pkg::alu_rsp_t rsp
);
    import rpn_pkg::*;

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_DIV  = 2'd1;
    localparam logic [1:0] A_FIX  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [WORD_W-1:0] result_reg, result_next;

    logic [WORD_W:0]   shifted;
    logic [WORD_W+1:0] diff;
    logic              borrow;
    logic [WORD_W-1:0] mag_a, mag_b;

    assign mag_a   = req.a[WORD_W-1] ? (~req.a + WORD_W'(1)) : req.a;
    assign mag_b   = req.b[WORD_W-1] ? (~req.b + WORD_W'(1)) : req.b;
    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign borrow  = diff[WORD_W+1];

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        neg_next    = neg_reg;
        result_next = result_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    if (req.op == FN_DIV)
                    begin
                        rem_next   = '0;
                        quo_next   = mag_a;
                        dvs_next   = mag_b;
                        neg_next   = req.a[WORD_W-1] ^ req.b[WORD_W-1];
                        step_next  = '0;
                        state_next = A_DIV;
                    end
                    else
                    begin
                        case (req.op)
                            FN_ADD:  result_next = req.a + req.b;
                            FN_SUB:  result_next = req.a - req.b;
                            default: result_next = req.a * req.b;
                        endcase
                        done_next = 1'b1;
                    end
                end
            end
            A_DIV:
            begin
                // restoring step: keep the difference unless it borrowed
                rem_next  = borrow ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
                quo_next  = {quo_reg[WORD_W-2:0], ~borrow};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(WORD_W - 1))
                begin
                    state_next = A_FIX;
                end
            end
            A_FIX:
            begin
                result_next = neg_reg ? (~quo_reg + WORD_W'(1)) : quo_reg;
                done_next   = 1'b1;
                state_next  = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

### rtl/rpn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_checker: port-level assertions for the RPN stack evaluator
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module rpn_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [2:0]         func,
    input logic signed [31:0] operand_value,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] answer,
    input logic [2:0]         status,
    input logic               is_final
);
    import rpn_pkg::*;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(answer)
            && $stable(status) && $stable(is_final))
        else $error("result changed while stalled");

    // only an ok finish carries a value
    a_answer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (!is_final || status != ST_OK) |-> answer == '0)
        else $error("nonzero answer outside an ok finish");

    // a finish request is answered in the next cycle
    a_finish_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FN_FINISH |=> out_valid && is_final)
        else $error("finish not answered in the next cycle");

    // a request is taken only when the result slot is empty or drains
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> out_ready)
        else $error("request taken while result slot stays full");

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (.*);

### tb/sv/rpn_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_result_checker: result checker for the RPN stack evaluator
// Watches both channels, evaluates every accepted token against its own copy
// of the operand stack and sticky error, and compares each returned result
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module rpn_result_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [2:0]         func,
    input  logic signed [31:0] operand_value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] answer,
    input  logic [2:0]         status,
    input  logic               is_final,
    output int unsigned        err_total,
    output int unsigned        outstanding,
    output int unsigned        live_tokens
);
    import rpn_pkg::*;

    typedef struct packed {
        logic [31:0] answer;
        logic [2:0]  status;
        logic        is_final;
    } token_result_t;

    logic [31:0]   calc_stack [STACK_DEPTH];
    int            calc_depth;
    logic [2:0]    calc_error;
    token_result_t pending_answers [$];
    int unsigned   errs;
    int unsigned   live;

    // Evaluate one token against the local stack; updates stack and error.
    function automatic token_result_t eval_token(input logic [2:0] fn,
                                                 input logic [31:0] val);
        token_result_t r;
        logic [31:0]   lhs;
        logic [31:0]   rhs;
        logic [31:0]   res;
        logic [31:0]   mag_l;
        logic [31:0]   mag_r;
        r.answer   = '0;
        r.status   = ST_OK;
        r.is_final = 1'b0;
        if (fn == FN_FINISH)
        begin
            r.is_final = 1'b1;
            if (calc_error != ST_OK)
                r.status = calc_error;
            else if (calc_depth != 1)
                r.status = ST_DEPTH;
            else
                r.answer = calc_stack[0];
            calc_depth = 0;
            calc_error = ST_OK;
            return r;
        end
        if (calc_error == ST_OK)
        begin
            case (fn)
                FN_PUSH:
                begin
                    if (calc_depth >= STACK_DEPTH)
                        calc_error = ST_FULL;
                    else
                    begin
                        calc_stack[calc_depth] = val;
                        calc_depth++;
                    end
                end
                FN_ADD, FN_SUB, FN_MUL, FN_DIV:
                begin
                    if (calc_depth < 2)
                        calc_error = ST_FEW;
                    else
                    begin
                        lhs = calc_stack[calc_depth - 2];
                        rhs = calc_stack[calc_depth - 1];
                        if (fn == FN_DIV && rhs == '0)
                            calc_error = ST_DIVZERO;
                        else
                        begin
                            case (fn)
                                FN_ADD: res = lhs + rhs;
                                FN_SUB: res = lhs - rhs;
                                FN_MUL: res = lhs * rhs;
                                default:
                                begin
                                    // divide magnitudes, truncating toward zero
                                    mag_l = lhs[31] ? -lhs : lhs;
                                    mag_r = rhs[31] ? -rhs : rhs;
                                    res   = mag_l / mag_r;
                                    if (lhs[31] != rhs[31])
                                        res = -res;
                                end
                            endcase
                            calc_depth--;
                            calc_stack[calc_depth - 1] = res;
                        end
                    end
                end
                default: calc_error = ST_BADOP;
            endcase
        end
        r.status = calc_error;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        token_result_t exp_r;
        if (!rst_n)
        begin
            calc_depth = 0;
            calc_error = ST_OK;
            pending_answers.delete();
            errs = 0;
            live = 0;
            err_total   <= 0;
            outstanding <= 0;
            live_tokens <= 0;
        end
        else
        begin
            // results first, so a result can never match a token taken at the same edge
            if (out_valid && out_ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected result, expected none actual answer %0d",
                             $time, answer);
                    $display("%0t: unexpected result, actual status %0d final %0b",
                             $time, status, is_final);
                end
                else
                begin
                    exp_r = pending_answers.pop_front();
                    if (answer !== exp_r.answer)
                    begin
                        errs++;
                        $display("%0t: answer mismatch, expected %0d actual %0d",
                                 $time, $signed(exp_r.answer), answer);
                    end
                    if (status !== exp_r.status)
                    begin
                        errs++;
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, exp_r.status, status);
                    end
                    if (is_final !== exp_r.is_final)
                    begin
                        errs++;
                        $display("%0t: is_final mismatch, expected %0b actual %0b",
                                 $time, exp_r.is_final, is_final);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                live++;
                pending_answers.push_back(eval_token(func, operand_value));
            end
            err_total   <= errs;
            outstanding <= pending_answers.size();
            live_tokens <= live;
        end
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the RPN stack evaluator
// Drives directed token sequences (extremes, every operator, every error)
// and then random expressions and noise with random idling on both channels;
// the result checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import rpn_pkg::*;

    // invalid token codes, not defined by the package
    localparam logic [2:0] FN_BAD_LO = 3'd6;
    localparam logic [2:0] FN_BAD_HI = 3'd7;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

    // Worst item: a full divide, the longest sender gap and the longest
    // receiver stall; ~850 items, with a wide margin on top.
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned LIVE_TARGET = 800;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic [2:0]         func          = FN_PUSH;
    logic signed [31:0] operand_value = '0;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    logic signed [31:0] answer;
    logic [2:0]         status;
    logic               is_final;

    int unsigned err_total;
    int unsigned outstanding;
    int unsigned live_tokens;
    int unsigned cycle_count = 0;
    int unsigned stall_left  = 0;

    // idling switches, changed per stimulus segment
    logic tx_gaps = 1'b0;
    logic rx_gaps = 1'b0;

    logic [2:0] arith_ops [4] = '{FN_ADD, FN_SUB, FN_MUL, FN_DIV};

    always #5 clk = ~clk;

    rpn_stack_evaluator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .answer        (answer),
        .status        (status),
        .is_final      (is_final)
    );

    rpn_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .answer        (answer),
        .status        (status),
        .is_final      (is_final),
        .err_total     (err_total),
        .outstanding   (outstanding),
        .live_tokens   (live_tokens)
    );

    // Gap length: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Operand mix: small values (so divide by zero shows up), extremes, full range.
    function automatic logic signed [31:0] pick_operand();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $signed($urandom_range(0, 18)) - 9;
        else if (r == 5)
        begin
            case ($urandom_range(0, 4))
                0:       return INT_MIN;
                1:       return INT_MAX;
                2:       return 0;
                3:       return -1;
                default: return 1;
            endcase
        end
        else
            return $urandom();
    endfunction

    // Receiver side: hold out_ready low for random stretches when enabled.
    always @(posedge clk)
    begin
        if (!rx_gaps)
            out_ready <= 1'b1;
        else if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
                stall_left <= pick_gap();
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Send one token request: optional idle gap, then hold valid until accepted.
    // Valid stays high when the next request follows without a gap.
    task automatic issue_token(input logic [2:0] fn, input logic signed [31:0] val);
        int unsigned gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= fn;
        operand_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and hold off until every expected result is back.
    // The extra edge lets the outstanding count catch the last accepted request.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // One well-formed expression with random content, closed by finish.
    task automatic run_expression();
        int unsigned pushes_left;
        int unsigned r;
        int          level;
        logic        push_first;
        r = $urandom_range(0, 99);
        if (r < 85)
            pushes_left = $urandom_range(1, 6);
        else if (r < 97)
            pushes_left = $urandom_range(7, 16);
        else
            pushes_left = $urandom_range(17, 19);   // overflows the stack
        // deep expressions push everything first so the stack really fills
        push_first = (pushes_left >= 12) || ($urandom_range(0, 4) == 0);
        level = 0;
        while (pushes_left > 0 || level > 1)
        begin
            if (level >= 2 && (pushes_left == 0 || (!push_first && $urandom_range(0, 2) == 0)))
            begin
                issue_token(arith_ops[$urandom_range(0, 3)], pick_operand());
                level--;
            end
            else
            begin
                issue_token(FN_PUSH, pick_operand());
                level++;
                pushes_left--;
            end
        end
        issue_token(FN_FINISH, pick_operand());
    endtask

    // Noise: random tokens of any code, usually closed by finish.
    task automatic run_noise();
        int unsigned count;
        count = $urandom_range(1, 8);
        repeat (count)
            issue_token(3'($urandom_range(0, 7)), pick_operand());
        if ($urandom_range(0, 9) < 7)
            issue_token(FN_FINISH, pick_operand());
    endtask

    initial
    begin
        int unsigned next_switch;
        int unsigned segment;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part, no idling ----------------
        // add wraps to the most negative value, which divided by -1 stays put
        issue_token(FN_PUSH, INT_MAX);
        issue_token(FN_PUSH, 1);
        issue_token(FN_ADD, 0);
        issue_token(FN_PUSH, -1);
        issue_token(FN_DIV, 0);
        issue_token(FN_FINISH, 0);
        // sub wraps the other way, mul wraps too; second-from-top op top order
        issue_token(FN_PUSH, INT_MIN);
        issue_token(FN_PUSH, 1);
        issue_token(FN_SUB, 0);
        issue_token(FN_PUSH, -2);
        issue_token(FN_MUL, 0);
        issue_token(FN_PUSH, -7);
        issue_token(FN_SUB, 0);
        issue_token(FN_PUSH, -2);
        issue_token(FN_DIV, 0);
        issue_token(FN_FINISH, 0);
        // divide by zero, then a push that the sticky error swallows
        issue_token(FN_PUSH, 7);
        issue_token(FN_PUSH, 0);
        issue_token(FN_DIV, 0);
        issue_token(FN_PUSH, 5);
        issue_token(FN_FINISH, 0);
        // too few operands, both bad operator codes
        issue_token(FN_ADD, INT_MAX);
        issue_token(FN_FINISH, 0);
        issue_token(FN_BAD_LO, 0);
        issue_token(FN_FINISH, 0);
        issue_token(FN_PUSH, 3);
        issue_token(FN_BAD_HI, INT_MIN);
        issue_token(FN_FINISH, 0);
        // bad final depth: empty stack and two values left
        issue_token(FN_FINISH, 0);
        issue_token(FN_PUSH, 1);
        issue_token(FN_PUSH, 2);
        issue_token(FN_FINISH, 0);
        // fill the stack with walking ones and extremes, then overflow it
        for (int i = 0; i <= STACK_DEPTH; i++)
            issue_token(FN_PUSH, (i == 0) ? INT_MIN : (i == 1) ? INT_MAX : (32'sd1 <<< i));
        issue_token(FN_FINISH, 0);

        // pause until everything has come back before the random part
        wait_drained();

        // ---------------- random part ----------------
        // Segments rotate through idling modes: none, sender only, receiver
        // only, both. Every other segment boundary drains the block first.
        segment     = 0;
        next_switch = live_tokens + 100;
        while (live_tokens < LIVE_TARGET)
        begin
            if (live_tokens >= next_switch)
            begin
                segment++;
                next_switch = live_tokens + 100;
                if (segment % 2 == 0)
                    wait_drained();
                tx_gaps <= segment[0];
                rx_gaps <= segment[1];
            end
            if ($urandom_range(0, 99) < 85)
                run_expression();
            else
                run_noise();
        end
        issue_token(FN_FINISH, 0);

        // drain, then allow for a full divide plus margin
        wait_drained();
        repeat (80) @(posedge clk);

        if (err_total == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
